### hw/rtl/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Types, codes and character classification shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package stl_pkg;

   localparam int unsigned MAX_BYTES_DEFAULT = 65536;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END  = 1'b1;

   localparam logic QUOTE_DOUBLE = 1'b0;
   localparam logic QUOTE_SINGLE = 1'b1;

   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;

   typedef enum logic [3:0] {
      TK_LPAREN = 4'd0,
      TK_RPAREN = 4'd1,
      TK_LBRACE = 4'd2,
      TK_RBRACE = 4'd3,
      TK_DOT    = 4'd4,
      TK_COMMA  = 4'd5,
      TK_COLON  = 4'd6,
      TK_SEMI   = 4'd7,
      TK_IDENT  = 4'd8,
      TK_STRING = 4'd9,
      TK_END    = 4'd10,
      TK_ERROR  = 4'd11
   } tok_kind_type;

   typedef enum logic [1:0] {
      MODE_SCAN   = 2'd0,
      MODE_IDENT  = 2'd1,
      MODE_STRING = 2'd2,
      MODE_SILENT = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CLS_SPACE,
      CLS_SYMBOL,
      CLS_LETTER,
      CLS_DIGIT,
      CLS_QUOTE,
      CLS_OTHER
   } char_class_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [15:0]  start;
      logic [15:0]  length;
   } token_type;

   typedef struct packed {
      logic      two;
      token_type tok0;
      token_type tok1;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } slot_type;

   function automatic char_class_type classify(input logic [7:0] c);
      char_class_type r;
      r = CLS_OTHER;
      if (c inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0C}) r = CLS_SPACE;
      else if (c inside {8'h28, 8'h29, 8'h7B, 8'h7D, 8'h2E, 8'h2C, 8'h3A, 8'h3B})
         r = CLS_SYMBOL;
      else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) r = CLS_LETTER;
      else if (c inside {[8'h30:8'h39]}) r = CLS_DIGIT;
      else if (c inside {CH_DQUOTE, CH_SQUOTE}) r = CLS_QUOTE;
      return r;
   endfunction

   function automatic tok_kind_type symbol_kind(input logic [7:0] c);
      tok_kind_type k;
      case (c)
         8'h28:   k = TK_LPAREN;
         8'h29:   k = TK_RPAREN;
         8'h7B:   k = TK_LBRACE;
         8'h7D:   k = TK_RBRACE;
         8'h2E:   k = TK_DOT;
         8'h2C:   k = TK_COMMA;
         8'h3A:   k = TK_COLON;
         8'h3B:   k = TK_SEMI;
         default: k = TK_ERROR;
      endcase
      return k;
   endfunction

   function automatic logic [15:0] sat16(input logic [16:0] v);
      return v[16] ? 16'hFFFF : v[15:0];
   endfunction

endpackage

### hw/rtl/stl_front.sv
// ----------------------------------------------------------------------------
// stl_front
// Accepts source bytes, tracks the lexer state and pushes the tokens caused
// by each item into the queue as one entry.
// ----------------------------------------------------------------------------
module stl_front #(
   parameter int unsigned MAX_BYTES = stl_pkg::MAX_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_opcode,
   input  logic [7:0]       req_source_byte,
   input  logic             q_full,
   output stl_pkg::slot_type push
);

   localparam logic [16:0] LEX_LIMIT = 17'((MAX_BYTES < 65536) ? MAX_BYTES : 65536);

   stl_pkg::mode_type mode_ff, mode_in;
   logic              quote_ff, quote_in;
   logic [16:0]       pos_ff, pos_in;
   logic [15:0]       pstart_ff, pstart_in;
   logic [15:0]       plen_ff, plen_in;

   logic                   accept;
   logic                   at_limit;
   logic                   is_end;
   logic [7:0]             delim;
   logic [15:0]            plen_inc;
   stl_pkg::char_class_type cls;
   logic                   a_v, b_v;
   stl_pkg::token_type     a_tok, b_tok;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign is_end    = (req_opcode == stl_pkg::OP_END);
   assign at_limit  = (pos_ff >= LEX_LIMIT);
   assign delim     = (quote_ff == stl_pkg::QUOTE_SINGLE) ? stl_pkg::CH_SQUOTE
                                                          : stl_pkg::CH_DQUOTE;
   assign cls       = stl_pkg::classify(req_source_byte);
   assign plen_inc  = stl_pkg::sat16({1'b0, plen_ff} + 17'd1);

   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         if (is_end) begin
            mode_in = stl_pkg::MODE_SCAN;
         end else if (mode_ff != stl_pkg::MODE_SILENT) begin
            if (at_limit) begin
               mode_in = stl_pkg::MODE_SILENT;
            end else if (mode_ff == stl_pkg::MODE_STRING) begin
               if (req_source_byte == delim) mode_in = stl_pkg::MODE_SCAN;
            end else if (mode_ff == stl_pkg::MODE_IDENT &&
                         (cls == stl_pkg::CLS_LETTER || cls == stl_pkg::CLS_DIGIT)) begin
               mode_in = stl_pkg::MODE_IDENT;
            end else begin
               case (cls)
                  stl_pkg::CLS_LETTER: mode_in = stl_pkg::MODE_IDENT;
                  stl_pkg::CLS_QUOTE:  mode_in = stl_pkg::MODE_STRING;
                  stl_pkg::CLS_SPACE,
                  stl_pkg::CLS_SYMBOL: mode_in = stl_pkg::MODE_SCAN;
                  default:             mode_in = stl_pkg::MODE_SILENT;
               endcase
            end
         end
      end
   end

   always_comb begin
      quote_in  = quote_ff;
      pos_in    = pos_ff;
      pstart_in = pstart_ff;
      plen_in   = plen_ff;
      a_v       = 1'b0;
      b_v       = 1'b0;
      a_tok     = '{kind: stl_pkg::TK_IDENT, start: pstart_ff, length: plen_ff};
      b_tok     = '{kind: stl_pkg::TK_END, start: stl_pkg::sat16(pos_ff), length: 16'd0};
      if (accept) begin
         if (is_end) begin
            if (mode_ff == stl_pkg::MODE_IDENT) begin
               a_v = 1'b1;
            end else if (mode_ff == stl_pkg::MODE_STRING) begin
               a_v        = 1'b1;
               a_tok.kind = stl_pkg::TK_ERROR;
            end
            b_v       = 1'b1;
            quote_in  = stl_pkg::QUOTE_DOUBLE;
            pos_in    = '0;
            pstart_in = '0;
            plen_in   = '0;
         end else if (mode_ff != stl_pkg::MODE_SILENT) begin
            if (at_limit) begin
               a_v        = (mode_ff == stl_pkg::MODE_IDENT);
               b_v        = 1'b1;
               b_tok.kind = stl_pkg::TK_ERROR;
            end else begin
               pos_in = pos_ff + 17'd1;
               if (mode_ff == stl_pkg::MODE_STRING) begin
                  if (req_source_byte == delim) begin
                     a_v        = 1'b1;
                     a_tok.kind = stl_pkg::TK_STRING;
                  end else begin
                     plen_in = plen_inc;
                  end
               end else if (mode_ff == stl_pkg::MODE_IDENT &&
                            (cls == stl_pkg::CLS_LETTER || cls == stl_pkg::CLS_DIGIT)) begin
                  plen_in = plen_inc;
               end else begin
                  a_v          = (mode_ff == stl_pkg::MODE_IDENT);
                  b_tok.start  = pos_ff[15:0];
                  b_tok.length = 16'd1;
                  case (cls)
                     stl_pkg::CLS_SPACE: begin
                     end
                     stl_pkg::CLS_SYMBOL: begin
                        b_v        = 1'b1;
                        b_tok.kind = stl_pkg::symbol_kind(req_source_byte);
                     end
                     stl_pkg::CLS_LETTER: begin
                        pstart_in = pos_ff[15:0];
                        plen_in   = 16'd1;
                     end
                     stl_pkg::CLS_QUOTE: begin
                        quote_in  = (req_source_byte == stl_pkg::CH_SQUOTE)
                                    ? stl_pkg::QUOTE_SINGLE : stl_pkg::QUOTE_DOUBLE;
                        pstart_in = stl_pkg::sat16(pos_ff + 17'd1);
                        plen_in   = 16'd0;
                     end
                     default: begin
                        b_v        = 1'b1;
                        b_tok.kind = stl_pkg::TK_ERROR;
                     end
                  endcase
               end
            end
         end
      end
   end

   always_comb begin
      push.valid      = a_v || b_v;
      push.entry.two  = a_v && b_v;
      push.entry.tok0 = a_v ? a_tok : b_tok;
      push.entry.tok1 = b_tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= stl_pkg::MODE_SCAN;
         quote_ff  <= stl_pkg::QUOTE_DOUBLE;
         pos_ff    <= '0;
         pstart_ff <= '0;
         plen_ff   <= '0;
      end else begin
         mode_ff   <= mode_in;
         quote_ff  <= quote_in;
         pos_ff    <= pos_in;
         pstart_ff <= pstart_in;
         plen_ff   <= plen_in;
      end
   end

endmodule

### hw/rtl/stl_queue.sv
// ----------------------------------------------------------------------------
// stl_queue
// Short queue of token entries between the front and the back.
// ----------------------------------------------------------------------------
module stl_queue (
   input  logic              clock,
   input  logic              reset,
   input  stl_pkg::slot_type push,
   output logic              full,
   input  logic              pop,
   output stl_pkg::slot_type head
);

   localparam int unsigned DEPTH = stl_pkg::QUEUE_DEPTH;
   localparam int unsigned PW    = $clog2(DEPTH);
   localparam int unsigned CW    = $clog2(DEPTH + 1);

   stl_pkg::entry_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push.entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/stl_back.sv
// ----------------------------------------------------------------------------
// stl_back
// Takes queue entries apart into single tokens and holds each one in the
// output register until the receiver takes it.
// ----------------------------------------------------------------------------
module stl_back (
   input  logic              clock,
   input  logic              reset,
   input  stl_pkg::slot_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [3:0]        rsp_token_kind,
   output logic [15:0]       rsp_token_start,
   output logic [15:0]       rsp_token_length,
   output logic              rsp_last_of_run
);

   logic               valid_ff, valid_in;
   logic               half_ff, half_in;
   stl_pkg::token_type tok_ff, tok_in;
   logic               last_ff, last_in;
   logic               load;
   logic               sel_last;

   assign load     = head.valid && (!valid_ff || rsp_ready);
   assign sel_last = !head.entry.two || half_ff;
   assign pop      = load && sel_last;

   always_comb begin
      valid_in = valid_ff;
      half_in  = half_ff;
      tok_in   = tok_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         tok_in   = half_ff ? head.entry.tok1 : head.entry.tok0;
         last_in  = sel_last;
         half_in  = !sel_last;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff  <= tok_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_token_kind   = tok_ff.kind;
   assign rsp_token_start  = tok_ff.start;
   assign rsp_token_length = tok_ff.length;
   assign rsp_last_of_run  = last_ff;

endmodule

### hw/rtl/script_token_lexer.sv
// ----------------------------------------------------------------------------
// script_token_lexer
// Streaming tokenizer: one source byte per item in, tokens out.
// ----------------------------------------------------------------------------
// The req_ channel carries one source byte per item, or an end mark
// (req_opcode high) that closes the buffer. The rsp_ channel gives one token
// per item: kind, start offset, length, and last_of_run on the final token
// caused by an input item. An item causes zero, one or two tokens.
//
// The front takes one item every cycle while the four-entry token queue has
// room. A token passes through the queue and then the output register before
// it appears on rsp_. The back delivers one token per cycle while the receiver
// takes them, so an item that causes two tokens is delivered one token at a
// time; the queue absorbs these bursts.
//
// When the receiver holds rsp_ready low the token waits in the output
// register, the queue fills, and req_ready falls once it is full.
// Reset puts the lexer between tokens at offset zero and empties the queue
// and output register. The end item returns the lexer to the same state.
module script_token_lexer #(
   parameter int unsigned MAX_BYTES = stl_pkg::MAX_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_source_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_of_run
);

   stl_pkg::slot_type push;
   stl_pkg::slot_type head;
   logic              q_full;
   logic              pop;

   stl_front #(
      .MAX_BYTES(MAX_BYTES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_source_byte (req_source_byte),
      .q_full          (q_full),
      .push            (push)
   );

   stl_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .pop   (pop),
      .head  (head)
   );

   stl_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

### hw/rtl/stl_checker.sv
// ----------------------------------------------------------------------------
// stl_checker
// Port-level checks on the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module stl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_token_kind,
   input logic [15:0] rsp_token_start,
   input logic [15:0] rsp_token_length,
   input logic        rsp_last_of_run
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind) &&
      $stable(rsp_token_start) && $stable(rsp_token_length) && $stable(rsp_last_of_run))
      else $error("Output token changed while stalled.");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Token shown right after reset.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == stl_pkg::TK_END |->
      rsp_last_of_run && rsp_token_length == 16'd0)
      else $error("End token is not closing its run or has nonzero length.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind <= stl_pkg::TK_SEMI |->
      rsp_token_length == 16'd1 && rsp_last_of_run)
      else $error("Symbol token has a bad length or is not last of its run.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind != stl_pkg::TK_IDENT && !rsp_last_of_run |->
      rsp_token_kind == stl_pkg::TK_ERROR)
      else $error("Only an identifier or error token may open a two-token run.");

endmodule

bind script_token_lexer stl_checker u_stl_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_token_kind   (rsp_token_kind),
   .rsp_token_start  (rsp_token_start),
   .rsp_token_length (rsp_token_length),
   .rsp_last_of_run  (rsp_last_of_run)
);
